// ===== hdl/satl_pkg.sv =====
// Shared types and constants for the set-associative tag lookup block.
`timescale 1ns / 1ps
`default_nettype none
package satl_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WAYS   = 2'd0;
    localparam logic [1:0] CFG_IDX    = 2'd1;
    localparam logic [1:0] CFG_POLICY = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int WAYS_CFG_W = 5;
    localparam int IDX_CFG_W  = 4;
    localparam int WAY_OUT_W  = 4;
    localparam int ETAG_OUT_W = 28;
    localparam int CNT_W      = 32;

    // Replacement policy codes
    localparam logic POL_LRU  = 1'b0;
    localparam logic POL_FIFO = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;      // clear one metadata row
        logic load;     // latch address split
        logic rd;       // read set rows
        logic eval;     // decide hit, way, new ranks
        logic commit;   // write back and load result
    } t_satl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last; // clearing the last row
    } t_satl_sts;

endpackage
`default_nettype wire

// ===== hdl/satl_ctrl.sv =====
// Controller state machine for the tag lookup: clear pass, sequencing, result handshake.
`timescale 1ns / 1ps
`default_nettype none
module satl_ctrl import satl_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    input  t_satl_sts  i_sts,
    output t_satl_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       commit;

    // Result register is free when empty or being drained this cycle
    assign commit = (r_state == S_WRITE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_READ;
            S_READ:  n_state = S_EVAL;
            S_EVAL:  n_state = S_WRITE;
            S_WRITE: if (commit) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Output valid: set on commit, dropped when the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.clr    = (r_state == S_CLEAR);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd     = (r_state == S_READ);
    assign o_cmd.eval   = (r_state == S_EVAL);
    assign o_cmd.commit = commit;

endmodule
`default_nettype wire

// ===== hdl/satl_dp.sv =====
// Datapath for the tag lookup: config, set memories, compare, replacement, counters.
`timescale 1ns / 1ps
`default_nettype none
module satl_dp import satl_pkg::*; #(
    parameter int MAX_SETS    = 1024,
    parameter int MAX_WAYS    = 16,
    parameter int BLOCK_BYTES = 16,
    parameter int ADDR_BITS   = 32
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  t_satl_cmd                  i_cmd,
    output t_satl_sts                  o_sts,
    input  wire                        i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]      i_cfg_data,
    input  wire  [ADDR_BITS-1:0]       i_address,
    output logic                       o_hit,
    output logic [WAY_OUT_W-1:0]       o_way_used,
    output logic                       o_evicted,
    output logic [ETAG_OUT_W-1:0]      o_evicted_tag,
    output logic [CNT_W-1:0]           o_miss_count,
    output logic [CNT_W-1:0]           o_access_count
);

    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int IDX_MAX  = $clog2(MAX_SETS);
    localparam int SET_W    = (IDX_MAX > 0) ? IDX_MAX : 1;
    localparam int TAG_W    = (ADDR_BITS > OFF_BITS) ? ADDR_BITS - OFF_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W   = WAY_W;
    localparam int ROW_W    = MAX_WAYS * TAG_W;
    localparam int RANKS_W  = MAX_WAYS * RANK_W;
    localparam int META_W   = MAX_WAYS + RANKS_W;

    // Configuration registers
    logic [WAYS_CFG_W-1:0] r_ways_cfg;
    logic [IDX_CFG_W-1:0]  r_idx_cfg;
    logic                  r_policy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_cfg <= WAYS_CFG_W'(1);
            r_idx_cfg  <= IDX_CFG_W'(10);
            r_policy   <= POL_LRU;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WAYS:   r_ways_cfg <= i_cfg_data[WAYS_CFG_W-1:0];
                CFG_IDX:    r_idx_cfg  <= i_cfg_data[IDX_CFG_W-1:0];
                CFG_POLICY: r_policy   <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Effective ways and index width after clamping
    logic [6:0] ways_eff;
    logic [4:0] idx_eff;
    always_comb begin
        priority if (r_ways_cfg == '0) begin
            ways_eff = 7'd1;
        end else if (7'(r_ways_cfg) > 7'(MAX_WAYS)) begin
            ways_eff = 7'(MAX_WAYS);
        end else begin
            ways_eff = 7'(r_ways_cfg);
        end
        idx_eff = (5'(r_idx_cfg) > 5'(IDX_MAX)) ? 5'(IDX_MAX) : 5'(r_idx_cfg);
    end

    // Address split
    logic [TAG_W-1:0] blk_c, tag_c;
    logic [SET_W-1:0] set_c, set_mask;
    assign blk_c    = TAG_W'(i_address >> OFF_BITS);
    assign tag_c    = blk_c >> idx_eff;
    assign set_mask = ~({SET_W{1'b1}} << idx_eff);
    assign set_c    = SET_W'(blk_c) & set_mask;

    logic [TAG_W-1:0] r_tag;
    logic [SET_W-1:0] r_set;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag <= tag_c;
            r_set <= set_c;
        end
    end

    // Clear pass address over the metadata rows
    logic [SET_W-1:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end
    assign o_sts.clr_last = (r_clr_addr == SET_W'(MAX_SETS - 1));

    // Set memories: tag row and metadata row (valid bits and age ranks)
    logic [ROW_W-1:0]  mem_tag  [MAX_SETS];
    logic [META_W-1:0] mem_meta [MAX_SETS];
    logic [ROW_W-1:0]  r_tag_row, n_tag_row;
    logic [META_W-1:0] r_meta;

    logic                r_hit, r_evict, r_meta_upd;
    logic [WAY_W-1:0]    r_way;
    logic [TAG_W-1:0]    r_ev_tag;
    logic [MAX_WAYS-1:0] r_new_valid;
    logic [RANKS_W-1:0]  r_new_rank;
    logic                tag_we, meta_we;

    assign tag_we  = i_cmd.commit && !r_hit;
    assign meta_we = i_cmd.commit && r_meta_upd;

    always_comb begin
        n_tag_row = r_tag_row;
        n_tag_row[r_way*TAG_W +: TAG_W] = r_tag;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_tag_row <= mem_tag[r_set];
        end
        if (tag_we) begin
            mem_tag[r_set] <= n_tag_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_meta <= mem_meta[r_set];
        end
        if (i_cmd.clr) begin
            mem_meta[r_clr_addr] <= '0;
        end else if (meta_we) begin
            mem_meta[r_set] <= {r_new_valid, r_new_rank};
        end
    end

    // Lookup and replacement decision
    logic [MAX_WAYS-1:0] valid_v, in_use, match, free_v, is_max;
    logic [RANK_W-1:0]   rank_a [MAX_WAYS];
    logic [TAG_W-1:0]    tag_a  [MAX_WAYS];
    logic                hit_c, free_any, promote, age_all;
    logic [WAY_W-1:0]    hit_way, free_way, vict_way, tgt;
    logic [RANK_W-1:0]   old_rank;
    logic [MAX_WAYS-1:0] nv_c;
    logic [RANKS_W-1:0]  nr_c;

    always_comb begin
        valid_v = r_meta[META_W-1 -: MAX_WAYS];
        for (int w = 0; w < MAX_WAYS; w++) begin
            rank_a[w] = r_meta[w*RANK_W +: RANK_W];
            tag_a[w]  = r_tag_row[w*TAG_W +: TAG_W];
            in_use[w] = (7'(w) < ways_eff);
            match[w]  = in_use[w] && valid_v[w] && (tag_a[w] == r_tag);
            free_v[w] = in_use[w] && !valid_v[w];
        end
        // A way is a maximum when no in-use way ranks above it
        for (int w = 0; w < MAX_WAYS; w++) begin
            is_max[w] = in_use[w];
            for (int v = 0; v < MAX_WAYS; v++) begin
                if (in_use[v] && (rank_a[v] > rank_a[w])) is_max[w] = 1'b0;
            end
        end
        hit_c    = |match;
        free_any = |free_v;
        hit_way  = '0;
        free_way = '0;
        vict_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w])  hit_way  = WAY_W'(w);
            if (free_v[w]) free_way = WAY_W'(w);
            if (is_max[w]) vict_way = WAY_W'(w);
        end
        priority if (hit_c) begin
            tgt = hit_way;
        end else if (free_any) begin
            tgt = free_way;
        end else begin
            tgt = vict_way;
        end
        promote  = !hit_c || (r_policy == POL_LRU);
        age_all  = !hit_c && free_any;
        old_rank = rank_a[tgt];
        nv_c     = valid_v;
        nv_c[tgt] = 1'b1;
        for (int w = 0; w < MAX_WAYS; w++) begin
            nr_c[w*RANK_W +: RANK_W] = rank_a[w];
            if (WAY_W'(w) == tgt) begin
                nr_c[w*RANK_W +: RANK_W] = '0;
            end else if (in_use[w] && valid_v[w] && (age_all || (rank_a[w] < old_rank))
                         && (rank_a[w] != {RANK_W{1'b1}})) begin
                nr_c[w*RANK_W +: RANK_W] = rank_a[w] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_hit       <= hit_c;
            r_way       <= tgt;
            r_evict     <= !hit_c && !free_any;
            r_ev_tag    <= (!hit_c && !free_any) ? tag_a[vict_way] : '0;
            r_new_valid <= nv_c;
            r_new_rank  <= nr_c;
            r_meta_upd  <= promote;
        end
    end

    // Saturating counters
    logic [CNT_W-1:0] r_miss_cnt, r_acc_cnt, n_miss_cnt, n_acc_cnt;
    always_comb begin
        n_acc_cnt  = (r_acc_cnt == '1) ? r_acc_cnt : r_acc_cnt + 1'b1;
        n_miss_cnt = (r_hit || (r_miss_cnt == '1)) ? r_miss_cnt : r_miss_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_cnt <= '0;
            r_acc_cnt  <= '0;
        end else if (i_cmd.commit) begin
            r_miss_cnt <= n_miss_cnt;
            r_acc_cnt  <= n_acc_cnt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit          <= r_hit;
            o_way_used     <= WAY_OUT_W'(r_way);
            o_evicted      <= r_evict;
            o_evicted_tag  <= ETAG_OUT_W'(r_ev_tag);
            o_miss_count   <= n_miss_cnt;
            o_access_count <= n_acc_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/set_assoc_cache_tag_lookup.sv =====
// Top level of the set-associative cache tag lookup with LRU or FIFO replacement.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_address
//  out     | output    | o_out_valid/i_out_stall | o_hit, o_way_used, o_evicted, ...
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Each beat passes from accept through set row read, lookup and victim choice
//  and write-back, all through the single-port set memories.
//  After reset a clearing pass over all MAX_SETS rows zeroes the valid and rank rows;
//  input stays stalled meanwhile, config writes are taken.
//  A new beat is accepted while a result still waits; write-back holds while
//  the result register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_tag_lookup import satl_pkg::*; #(
    parameter int MAX_SETS    = 1024,
    parameter int MAX_WAYS    = 16,
    parameter int BLOCK_BYTES = 16,
    parameter int ADDR_BITS   = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire  [ADDR_BITS-1:0]  i_address,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic                  o_hit,
    output logic [WAY_OUT_W-1:0]  o_way_used,
    output logic                  o_evicted,
    output logic [ETAG_OUT_W-1:0] o_evicted_tag,
    output logic [CNT_W-1:0]      o_miss_count,
    output logic [CNT_W-1:0]      o_access_count,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    t_satl_cmd cmd;
    t_satl_sts sts;

    assign o_cfg_ready = 1'b1;

    satl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    satl_dp #(
        .MAX_SETS    (MAX_SETS),
        .MAX_WAYS    (MAX_WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_address      (i_address),
        .o_hit          (o_hit),
        .o_way_used     (o_way_used),
        .o_evicted      (o_evicted),
        .o_evicted_tag  (o_evicted_tag),
        .o_miss_count   (o_miss_count),
        .o_access_count (o_access_count)
    );

endmodule
`default_nettype wire
